>>> hdl/pffl_pkg.sv
// ---------------------------------------------------------------------------
// Page frame free list package
// Request and response types, command codes and controller states used by
// the allocator top level; the link memory does not import this package.
// ---------------------------------------------------------------------------
package pffl_pkg;

  localparam int ADDR_W      = 32;
  localparam int FRAME_SHIFT = 12;
  localparam int PFN_W       = ADDR_W - FRAME_SHIFT;
  // Frame cursor: one bit above a frame number so it can hold the capacity.
  localparam int CUR_W       = PFN_W + 1;
  localparam int CNT_W       = 13;
  localparam int CMD_W       = 2;

  localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
  localparam logic [ADDR_W-1:0] USABLE_TYPE = 32'd1;
  localparam logic [ADDR_W-1:0] FRAME_MASK  = 32'h0000_0FFF;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_length;
    logic [ADDR_W-1:0] region_type;
    logic [ADDR_W-1:0] frame_addr;
  } in_req_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] alloc_addr;
    logic [CNT_W-1:0]  frames_added;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_ALLOC,
    ST_WAIT
  } state_t;

endpackage

>>> hdl/pffl_link_ram.sv
// ---------------------------------------------------------------------------
// Page frame free list link memory
// Simple dual-port synchronous RAM holding the next link of every frame,
// one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pffl_link_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/page_frame_free_list.sv
// Free, unused commands and allocate on an empty list are answered from the idle state; an
// allocate first does one link memory read; a region load passes a prepare state and then
// pushes its frames, one push per cycle through the link memory write port.
// A new request is taken once the previous one has reached the output register.
// Reset empties the list and sets free_start to 0x100000; link memory contents stay
// undefined and need no clearing pass.
// ---------------------------------------------------------------------------
// Page frame free list
// LIFO allocator of 4 KiB page frames kept as a head index plus a link
// memory with one next-index entry per frame.
// ---------------------------------------------------------------------------
module page_frame_free_list
  import pffl_pkg::*;
#(
  parameter int FRAME_CAPACITY = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output out_rsp_t          out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(FRAME_CAPACITY);
  localparam logic [CUR_W-1:0] CAP_C = CUR_W'(FRAME_CAPACITY);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic              head_vld_r, head_vld_nxt;
  logic [CUR_W-1:0]  cur_r, cur_nxt;
  logic [CUR_W-1:0]  end_r, end_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [PFN_W-1:0]  upper_r, upper_nxt;
  out_rsp_t          res_r, res_nxt;
  out_rsp_t          out_rsp_r, out_rsp_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [ADDR_W-1:0] free_start_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W:0]    wr_data;
  logic              rd_en;
  logic [IDX_W:0]    rd_data;

  logic              slot_free;
  logic              finish;
  out_rsp_t          fin_rsp;
  logic [ADDR_W-1:0] region_end;
  logic [ADDR_W:0]   base_rnd;
  logic [CUR_W-1:0]  hi_pfn;
  logic [CUR_W-1:0]  free_pfn;

  pffl_link_ram #(
    .DEPTH(FRAME_CAPACITY),
    .WIDTH(IDX_W + 1)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;
  assign slot_free = !out_vld_r || !out_stall;

  assign region_end = in_req.region_base + in_req.region_length;
  assign base_rnd   = {1'b0, base_r} + {1'b0, FRAME_MASK};
  assign hi_pfn     = {1'b0, upper_r};
  assign free_pfn   = {1'b0, in_req.frame_addr[ADDR_W-1:FRAME_SHIFT]};

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    head_vld_nxt = head_vld_r;
    cur_nxt      = cur_r;
    end_nxt      = end_r;
    cnt_nxt      = cnt_r;
    base_nxt     = base_r;
    upper_nxt    = upper_r;
    res_nxt      = res_r;
    out_rsp_nxt  = out_rsp_r;
    out_vld_nxt  = out_vld_r && out_stall;
    wr_en        = 1'b0;
    wr_addr      = cur_r[IDX_W-1:0];
    wr_data      = {head_vld_r, head_r};
    rd_en        = 1'b0;
    finish       = 1'b0;
    fin_rsp      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_req.cmd)
            CMD_LOAD: begin
              if (in_req.region_type == USABLE_TYPE) begin
                base_nxt  = (in_req.region_base > free_start_r) ? in_req.region_base
                                                                : free_start_r;
                upper_nxt = region_end[ADDR_W-1:FRAME_SHIFT];
                state_nxt = ST_PREP;
              end else begin
                finish = 1'b1;
              end
            end
            CMD_ALLOC: begin
              if (head_vld_r) begin
                rd_en     = 1'b1;
                state_nxt = ST_ALLOC;
              end else begin
                finish         = 1'b1;
                fin_rsp.status = STATUS_EMPTY;
              end
            end
            CMD_FREE: begin
              if (free_pfn < CAP_C) begin
                wr_en        = 1'b1;
                wr_addr      = free_pfn[IDX_W-1:0];
                head_nxt     = free_pfn[IDX_W-1:0];
                head_vld_nxt = 1'b1;
              end
              finish = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_PREP: begin
        // A base that rounds up past the top of the address space loads nothing.
        cur_nxt = {1'b0, base_rnd[ADDR_W-1:FRAME_SHIFT]};
        if (base_rnd[ADDR_W]) begin
          end_nxt = '0;
        end else if (hi_pfn > CAP_C) begin
          end_nxt = CAP_C;
        end else begin
          end_nxt = hi_pfn;
        end
        cnt_nxt   = '0;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (cur_r < end_r) begin
          wr_en        = 1'b1;
          head_nxt     = cur_r[IDX_W-1:0];
          head_vld_nxt = 1'b1;
          cur_nxt      = cur_r + CUR_W'(1);
          if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else begin
          finish               = 1'b1;
          fin_rsp.frames_added = cnt_r;
        end
      end
      ST_ALLOC: begin
        head_nxt           = rd_data[IDX_W-1:0];
        head_vld_nxt       = rd_data[IDX_W];
        fin_rsp.alloc_addr = {PFN_W'(head_r), {FRAME_SHIFT{1'b0}}};
        finish             = 1'b1;
      end
      ST_WAIT: begin
        if (slot_free) begin
          out_rsp_nxt = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A finished response goes straight to the output register when it is free.
    if (finish) begin
      if (slot_free) begin
        out_rsp_nxt = fin_rsp;
        out_vld_nxt = 1'b1;
        state_nxt   = ST_IDLE;
      end else begin
        res_nxt   = fin_rsp;
        state_nxt = ST_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
      free_start_r <= 32'h0010_0000;
    end else begin
      state_r    <= state_nxt;
      head_vld_r <= head_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        free_start_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r    <= head_nxt;
    cur_r     <= cur_nxt;
    end_r     <= end_nxt;
    cnt_r     <= cnt_nxt;
    base_r    <= base_nxt;
    upper_r   <= upper_nxt;
    res_r     <= res_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule
